@@ hw/rtl/xmd_pkg.sv @@
// Package for the x86 multiply/divide unit: operation codes, status codes,
// stage payload type and small helper functions. No dependencies.
`default_nettype none
package xmd_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned Stages = 64;

  typedef enum logic [1:0] {
    KIND_MULU = 2'd0,
    KIND_MULS = 2'd1,
    KIND_DIVU = 2'd2,
    KIND_DIVS = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DIV0  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_32 = 2'd2;

  // Payload handed from cell to cell. For divides acc is the partial
  // remainder and quo the shifting dividend/quotient; for multiplies acc is
  // the partial product and quo the shifting multiplier.
  typedef struct packed {
    logic             valid;
    logic [1:0]       kind;
    logic [1:0]       wcode;
    logic             neg_a;
    logic             neg_q;
    logic             div0;
    logic [DataW-1:0] acc;
    logic [DataW-1:0] quo;
    logic [DataW-1:0] opd;
  } cell_t;

  function automatic logic [DataW-1:0] wmask(input logic [1:0] code);
    logic [DataW-1:0] m;
    case (code)
      WIDTH_8:  m = 64'h0000_0000_0000_00ff;
      WIDTH_16: m = 64'h0000_0000_0000_ffff;
      default:  m = 64'h0000_0000_ffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic [DataW-1:0] sext(input logic [DataW-1:0] v,
                                            input logic [1:0] code);
    logic [DataW-1:0] m;
    logic [DataW-1:0] t;
    m = wmask(code);
    t = (m >> 1) + 64'd1;
    return ((v & m) ^ t) - t;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/x86_mul_div_unit.sv @@
// Top level of the x86 multiply/divide unit: operand set-up, a chain of
// 64 bit-step cells, and the finishing stage. Depends on xmd_pkg, xmd_cell,
// xmd_finish.
// Registers in order: the set-up register loaded at the accepting edge, one
// cell per bit of the 64-bit operand, then the output register.
// Throughput: one transaction per cycle; the whole chain holds while the
// output register is full and not taken.
// Reset: rst, synchronous active high, clears every stage valid bit.
`default_nettype none
module x86_mul_div_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // kind[1:0], width_code[3:2], operand_a[67:4], operand_b[131:68], zero
  input  wire logic [135:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // main_result[63:0], remainder_out[127:64], carry_overflow[128],
  // sign_flag[129], parity_flag[130], flags_written[131], status[133:132]
  output logic [135:0]      m_tdata
);
  import xmd_pkg::*;

  cell_t            chain [Stages+1];
  cell_t            setup;
  logic             stall;
  logic [1:0]       kind, wc;
  logic [DataW-1:0] a, b, ma, mb;

  assign kind = s_tdata[1:0];
  assign wc   = s_tdata[3:2];
  assign a    = s_tdata[67:4];
  assign b    = s_tdata[131:68];
  assign s_tready = !stall;

  always_comb begin
    ma = a; mb = b;
    setup.neg_a = 1'b0;
    setup.neg_q = 1'b0;
    case (kind)
      KIND_MULU: begin ma = a & wmask(wc); mb = b & wmask(wc); end
      KIND_MULS: begin ma = sext(a, wc); mb = sext(b, wc); end
      KIND_DIVS: begin
        setup.neg_a = a[DataW-1];
        setup.neg_q = a[DataW-1] ^ b[DataW-1];
        ma = a[DataW-1] ? 64'd0 - a : a;
        mb = b[DataW-1] ? 64'd0 - b : b;
      end
      default: ;
    endcase
    setup.valid = s_tvalid;
    setup.kind  = kind;
    setup.wcode = wc;
    setup.div0  = (b == 64'd0);
    setup.acc   = 64'd0;
    setup.quo   = kind[1] ? ma : mb;
    setup.opd   = kind[1] ? mb : ma;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (!stall) begin
      chain[0].valid <= setup.valid;
    end
    if (!stall) begin
      chain[0].kind  <= setup.kind;
      chain[0].wcode <= setup.wcode;
      chain[0].neg_a <= setup.neg_a;
      chain[0].neg_q <= setup.neg_q;
      chain[0].div0  <= setup.div0;
      chain[0].acc   <= setup.acc;
      chain[0].quo   <= setup.quo;
      chain[0].opd   <= setup.opd;
    end
  end

  for (genvar i = 0; i < Stages; i++) begin : g_cell
    xmd_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (!stall),
      .din (chain[i]),
      .dout(chain[i+1])
    );
  end

  xmd_finish u_finish (
    .clk     (clk),
    .rst     (rst),
    .din     (chain[Stages]),
    .stall   (stall),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );
endmodule
`default_nettype wire

@@ hw/rtl/xmd_cell.sv @@
// One bit step of the multiply/divide chain: a shift-add or a restoring
// subtract, then a register. Depends on xmd_pkg.
`default_nettype none
module xmd_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  xmd_pkg::cell_t     din,
  output xmd_pkg::cell_t     dout
);
  import xmd_pkg::*;

  cell_t            nxt;
  logic [DataW:0]   trial;
  logic [DataW-1:0] shifted;

  always_comb begin
    nxt     = din;
    shifted = {din.acc[DataW-2:0], din.quo[DataW-1]};
    trial   = {din.acc[DataW-1], shifted} - {1'b0, din.opd};
    if (din.kind[1]) begin
      // restoring divide: remainder bit-in from quotient register top
      if (!trial[DataW]) begin
        nxt.acc = trial[DataW-1:0];
        nxt.quo = {din.quo[DataW-2:0], 1'b1};
      end else begin
        nxt.acc = shifted;
        nxt.quo = {din.quo[DataW-2:0], 1'b0};
      end
    end else begin
      // multiply, multiplier bit from LSB, product modulo 2^64
      nxt.acc = din.quo[0] ? din.acc + din.opd : din.acc;
      nxt.opd = {din.opd[DataW-2:0], 1'b0};
      nxt.quo = {1'b0, din.quo[DataW-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.kind  <= nxt.kind;
      dout.wcode <= nxt.wcode;
      dout.neg_a <= nxt.neg_a;
      dout.neg_q <= nxt.neg_q;
      dout.div0  <= nxt.div0;
      dout.acc   <= nxt.acc;
      dout.quo   <= nxt.quo;
      dout.opd   <= nxt.opd;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/xmd_finish.sv @@
// Final stage: signs, range check, flags and output register.
// Depends on xmd_pkg.
`default_nettype none
module xmd_finish (
  input  wire logic          clk,
  input  wire logic          rst,
  input  xmd_pkg::cell_t     din,
  output logic               stall,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [135:0]       m_tdata
);
  import xmd_pkg::*;

  logic [DataW-1:0] res, rem, m, top, lim;
  logic             co, sf, pf, fw;
  logic [1:0]       st;
  logic [135:0]     pk;
  logic             full;

  always_comb begin
    m   = wmask(din.wcode);
    top = (m >> 1) + 64'd1;
    res = 64'd0; rem = 64'd0; co = 1'b0; sf = 1'b0; pf = 1'b0; fw = 1'b0;
    st  = ST_OK;
    lim = m;
    if (!din.kind[1]) begin
      res = din.acc;
      fw  = 1'b1;
      sf  = |(res & top);
      pf  = ~^res[7:0];
      if (din.kind == KIND_MULU) co = |(res & ~m);
      else                       co = (sext(res, din.wcode) != res);
    end else if (din.div0) begin
      st = ST_DIV0;
    end else begin
      if (din.kind == KIND_DIVS) lim = din.neg_q ? top : (m >> 1);
      if (din.quo > lim) begin
        st = ST_RANGE;
      end else begin
        res = din.neg_q ? 64'd0 - din.quo : din.quo;
        rem = din.neg_a ? 64'd0 - din.acc : din.acc;
      end
    end
    pk = {2'b00, st, fw, pf, sf, co, rem, res};
  end

  assign full  = m_tvalid;
  assign stall = full && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!stall) begin
      m_tvalid <= din.valid;
    end
    if (!stall) m_tdata <= pk;
  end
endmodule
`default_nettype wire

@@ hw/rtl/xmd_checker.sv @@
// Port-level checks for the x86 multiply/divide unit, bound to the top level.
// Depends on xmd_pkg for status codes.
`default_nettype none
module xmd_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [135:0] m_tdata
);
  import xmd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[133:132] != 2'd3)
    else $error("bad status");

  a_divflags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[131] |-> m_tdata[130:128] == 3'd0)
    else $error("divide wrote flags");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[133:132] != ST_OK |-> m_tdata[127:0] == 128'd0)
    else $error("error result not zero");
endmodule

bind x86_mul_div_unit xmd_checker u_xmd_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

@@ sim/tb.sv @@
// Testbench for x86_mul_div_unit: random and directed multiply/divide
// transactions, each result checked against an in-line predictor.
// Depends on xmd_pkg and the unit's RTL.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import xmd_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  wcode;
    logic [63:0] a;
    logic [63:0] b;
  } op_t;

  // lowest field last, to match the result bus packing
  typedef struct packed {
    logic [1:0]  st;
    logic        fw;
    logic        pf;
    logic        sf;
    logic        co;
    logic [63:0] rem;
    logic [63:0] res;
  } res_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [135:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [135:0] m_tdata;

  op_t    pending_ops[$];
  res_t   expected_results[$];
  int     in_idle_pct;
  int     out_idle_pct;
  bit     failed;
  longint cycles;

  x86_mul_div_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  function automatic logic [63:0] size_mask(logic [1:0] w);
    if (w == WIDTH_8) return 64'hff;
    if (w == WIDTH_16) return 64'hffff;
    return 64'hffff_ffff;
  endfunction

  function automatic logic [63:0] widen_signed(logic [63:0] v, logic [63:0] m);
    logic [63:0] t;
    t = (m >> 1) + 64'd1;
    return ((v & m) ^ t) - t;
  endfunction

  function automatic res_t compute_muldiv(op_t op);
    res_t r;
    logic [63:0] m, t, ma, mb, qm, rm, lim;
    logic na, nb, nq;
    r = '0;
    m = size_mask(op.wcode);
    t = (m >> 1) + 64'd1;
    case (kind_t'(op.kind))
      KIND_MULU, KIND_MULS: begin
        if (op.kind == KIND_MULU) begin
          r.res = (op.a & m) * (op.b & m);
          r.co = (r.res & ~m) != 0;
        end else begin
          r.res = widen_signed(op.a, m) * widen_signed(op.b, m);
          r.co = widen_signed(r.res, m) != r.res;
        end
        r.sf = (r.res & t) != 0;
        r.pf = ~^r.res[7:0];
        r.fw = 1'b1;
      end
      KIND_DIVU: begin
        if (op.b == 0) r.st = ST_DIV0;
        else if (op.a / op.b > m) r.st = ST_RANGE;
        else begin
          r.res = op.a / op.b;
          r.rem = op.a % op.b;
        end
      end
      default: begin
        if (op.b == 0) r.st = ST_DIV0;
        else begin
          na = op.a[63];
          nb = op.b[63];
          ma = na ? -op.a : op.a;
          mb = nb ? -op.b : op.b;
          qm = ma / mb;
          rm = ma % mb;
          nq = na != nb;
          lim = nq ? t : (m >> 1);
          if (qm > lim) r.st = ST_RANGE;
          else begin
            r.res = nq ? -qm : qm;
            r.rem = na ? -rm : rm;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] t_edge(logic [63:0] m);
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return 64'd1;
      2: return '1;
      3: return m;
      4: return m >> 1;
      5: return (m >> 1) + 64'd1;
      6: return 64'h8000_0000_0000_0000;
      default: return -((m >> 1) + 64'd1);
    endcase
  endfunction

  // Operands biased towards edge patterns and quotients that fit the size.
  function automatic op_t random_op();
    op_t op;
    logic [63:0] m;
    op.kind = 2'($urandom_range(0, 3));
    op.wcode = 2'($urandom_range(0, 3));
    m = size_mask(op.wcode);
    case ($urandom_range(0, 5))
      0: begin op.a = rand64(); op.b = rand64(); end
      1: begin
        op.a = rand64() & m;
        op.b = rand64() & m;
      end
      2: begin
        op.a = {$urandom_range(0, 1) ? 32'hffff_ffff : 32'h0, $urandom()};
        op.b = {$urandom_range(0, 1) ? 32'hffff_ffff : 32'h0, $urandom()};
      end
      3: begin
        op.b = rand64() >> $urandom_range(0, 63);
        if (op.b == 0) op.b = 64'd1;
        op.a = op.b * (rand64() & (m >> $urandom_range(0, 8))) + (rand64() % op.b);
        if ($urandom_range(0, 1)) begin op.a = -op.a; end
        if ($urandom_range(0, 1)) begin op.b = -op.b; end
      end
      4: begin
        op.a = $urandom_range(0, 1) ? t_edge(m) : rand64();
        op.b = $urandom_range(0, 3) == 0 ? 64'd0 : t_edge(m);
      end
      default: begin
        op.a = rand64() & 64'h0000_0000_ffff_ffff;
        op.b = {56'd0, 8'($urandom_range(1, 255))};
      end
    endcase
    return op;
  endfunction

  task automatic add_op(logic [1:0] k, logic [1:0] w, logic [63:0] a, logic [63:0] b);
    op_t op;
    op.kind = k;
    op.wcode = w;
    op.a = a;
    op.b = b;
    pending_ops.push_back(op);
  endtask

  task automatic drain();
    while (pending_ops.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(compute_muldiv(pending_ops.pop_front()));
      end
      if (pending_ops.size() != 0 &&
          ((s_tvalid && !s_tready) || $urandom_range(0, 99) >= in_idle_pct)) begin
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, pending_ops[0].b, pending_ops[0].a,
                    pending_ops[0].wcode, pending_ops[0].kind};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    res_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[133:0];
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction %h", m_tdata);
          failed <= 1'b1;
        end else begin
          want = expected_results.pop_front();
          if (got.res !== want.res) begin
            $error("main_result exp %h got %h", want.res, got.res); failed <= 1'b1;
          end
          if (got.rem !== want.rem) begin
            $error("remainder_out exp %h got %h", want.rem, got.rem); failed <= 1'b1;
          end
          if (got.co !== want.co) begin
            $error("carry_overflow exp %b got %b", want.co, got.co); failed <= 1'b1;
          end
          if (got.sf !== want.sf) begin
            $error("sign_flag exp %b got %b", want.sf, got.sf); failed <= 1'b1;
          end
          if (got.pf !== want.pf) begin
            $error("parity_flag exp %b got %b", want.pf, got.pf); failed <= 1'b1;
          end
          if (got.fw !== want.fw) begin
            $error("flags_written exp %b got %b", want.fw, got.fw); failed <= 1'b1;
          end
          if (got.st !== want.st) begin
            $error("status exp %0d got %0d", want.st, got.st); failed <= 1'b1;
          end
        end
      end
      m_tready <= $urandom_range(0, 99) >= out_idle_pct;
    end
  end

  initial begin
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    failed = 1'b0;
    cycles = 0;
    in_idle_pct = 35;
    out_idle_pct = 76;
    // directed: extremes, every kind, zero divisor, range overflow
    add_op(KIND_MULU, WIDTH_8, 64'hff, 64'hff);
    add_op(KIND_MULU, WIDTH_16, '1, '1);
    add_op(KIND_MULU, WIDTH_32, 64'hffff_ffff, 64'hffff_ffff);
    add_op(KIND_MULU, 2'd3, 64'h1234_5678_0000_0003, 64'h5);
    add_op(KIND_MULS, WIDTH_8, 64'h80, 64'h80);
    add_op(KIND_MULS, WIDTH_8, 64'h7f, 64'h7f);
    add_op(KIND_MULS, WIDTH_16, 64'h8000, 64'hffff);
    add_op(KIND_MULS, WIDTH_32, 64'h8000_0000, 64'h7fff_ffff);
    add_op(KIND_MULS, WIDTH_32, 64'hffff_ffff, 64'h1);
    add_op(KIND_MULU, WIDTH_8, 64'd0, 64'd0);
    add_op(KIND_DIVU, WIDTH_8, 64'd100, 64'd0);
    add_op(KIND_DIVS, WIDTH_32, '1, 64'd0);
    add_op(KIND_DIVU, WIDTH_8, 64'h100, 64'd1);
    add_op(KIND_DIVU, WIDTH_8, 64'hff, 64'd1);
    add_op(KIND_DIVU, WIDTH_32, '1, '1);
    add_op(KIND_DIVU, WIDTH_16, 64'h1_2345, 64'h7);
    add_op(KIND_DIVS, WIDTH_32, 64'h8000_0000_0000_0000, '1);
    add_op(KIND_DIVS, WIDTH_8, -64'd128, 64'd1);
    add_op(KIND_DIVS, WIDTH_8, 64'd128, 64'd1);
    add_op(KIND_DIVS, WIDTH_16, -64'd7, 64'd2);
    add_op(KIND_DIVS, WIDTH_16, 64'd7, -64'd2);
    add_op(KIND_DIVS, 2'd3, -64'd100, -64'd3);
    add_op(KIND_DIVS, WIDTH_32, 64'h7fff_ffff, 64'd1);
    add_op(KIND_DIVS, WIDTH_32, -64'h8000_0000, 64'd1);
    for (int i = 0; i < 600; i++) begin
      if (i == 200) begin
        drain();
        in_idle_pct = 76;
        out_idle_pct = 35;
      end else if (i == 400) begin
        drain();
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      pending_ops.push_back(random_op());
    end
    drain();
    repeat (200) @(posedge clk);
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
